### src/dklp_pkg.sv
// Shared constants, types and functions of the directed (k,l)-plex checker.
`default_nettype none
package dklp_pkg;

    localparam int VERTICES = 64;
    localparam int ADDR_W = $clog2(VERTICES);
    localparam int ROW_W = 64;
    localparam int SET_IDX_W = $clog2(ROW_W);
    localparam int CNT_W = 7;
    localparam int SUM_W = CNT_W + 1;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] CMD_OUT_ROW = 2'd0;
    localparam logic [1:0] CMD_IN_ROW = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    localparam logic [1:0] REG_OUT_SLACK = 2'd0;
    localparam logic [1:0] REG_IN_SLACK = 2'd1;
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd2;

    localparam logic [CNT_W-1:0] OUT_SLACK_RST = 7'd2;
    localparam logic [CNT_W-1:0] IN_SLACK_RST = 7'd2;
    localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

    localparam logic [1:0] DRAIN_LAST = 2'd2;

    typedef struct packed {
        logic clear;
        logic valid;
        logic member;
    } t_deg_ctl;

    function automatic logic [CNT_W-1:0] popcount(input logic [ROW_W-1:0] x);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < ROW_W; i++) begin
            c = c + CNT_W'(x[i]);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### src/dklp_adj_mem.sv
// One adjacency matrix: a row memory with per-row valid bits so reset reads as zero.
`default_nettype none
module dklp_adj_mem (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_we,
    input  wire logic [dklp_pkg::ADDR_W-1:0]    i_waddr,
    input  wire logic [dklp_pkg::ROW_W-1:0]     i_wdata,
    input  wire logic [dklp_pkg::ADDR_W-1:0]    i_raddr,
    output logic      [dklp_pkg::ROW_W-1:0]     o_rdata
);

    logic [dklp_pkg::ROW_W-1:0]    r_mem [dklp_pkg::VERTICES];
    logic [dklp_pkg::VERTICES-1:0] r_valid;
    logic [dklp_pkg::ROW_W-1:0]    r_rdata;
    logic                          r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule
`default_nettype wire

### src/dklp_degree_unit.sv
// Shared degree unit: counts one member's out- and in-neighbours and flags a bound miss.
`default_nettype none
module dklp_degree_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dklp_pkg::t_deg_ctl            i_ctl,
    input  wire logic [dklp_pkg::ROW_W-1:0]    i_out_row,
    input  wire logic [dklp_pkg::ROW_W-1:0]    i_in_row,
    input  wire logic [dklp_pkg::ROW_W-1:0]    i_tset,
    input  wire logic [dklp_pkg::CNT_W-1:0]    i_bound,
    input  wire logic [dklp_pkg::CNT_W-1:0]    i_out_slack,
    input  wire logic [dklp_pkg::CNT_W-1:0]    i_in_slack,
    output logic                               o_fail
);

    dklp_pkg::t_deg_ctl            r_s1;
    dklp_pkg::t_deg_ctl            r_s2;
    logic [dklp_pkg::CNT_W-1:0]    r_ko;
    logic [dklp_pkg::CNT_W-1:0]    r_ki;
    logic                          r_fail;
    logic [dklp_pkg::SUM_W-1:0]    out_sum;
    logic [dklp_pkg::SUM_W-1:0]    in_sum;
    logic                          miss;

    assign out_sum = dklp_pkg::SUM_W'(r_ko) + dklp_pkg::SUM_W'(i_out_slack);
    assign in_sum = dklp_pkg::SUM_W'(r_ki) + dklp_pkg::SUM_W'(i_in_slack);
    assign miss = (out_sum < dklp_pkg::SUM_W'(i_bound)) ||
                  (in_sum < dklp_pkg::SUM_W'(i_bound));

    always_ff @(posedge i_clk) begin
        r_ko <= dklp_pkg::popcount(i_out_row & i_tset);
        r_ki <= dklp_pkg::popcount(i_in_row & i_tset);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_fail <= 1'b0;
        end else begin
            r_s1 <= i_ctl;
            r_s2 <= r_s1;
            if (i_ctl.clear) begin
                r_fail <= 1'b0;
            end else if (r_s2.valid && r_s2.member && miss) begin
                r_fail <= 1'b1;
            end
        end
    end

    assign o_fail = r_fail;

endmodule
`default_nettype wire

### src/directed_kl_plex_checker.sv
// Top level: configuration registers, adjacency memories and the check sequencer.
//
// A load command writes one adjacency row and leaves busy low.
// A check command raises busy and walks the in-use vertices one per cycle through
// a single shared degree unit fed by the two row memories. With nv in-use
// vertices, the plex pass scans all nv of them and drains the degree unit; if it
// holds, each vertex outside the subset is tried in turn by a further scan and
// drain, stopping at the first one that can be added, and each member vertex is
// skipped in the candidate walk. The walk closes when the candidate reaches nv,
// and ST_DONE holds the result. The worst case at nv=64 is a plex with no members
// that no single vertex extends; busy stays high until the check ends, so no next
// command can be accepted before then. The result appears for exactly one cycle
// with o_done high, and the receiver cannot stall it; busy falls at the end of that
// cycle.
`default_nettype none
module directed_kl_plex_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          i_command,
    input  wire logic [5:0]                          i_row_index,
    input  wire logic [dklp_pkg::ROW_W-1:0]          i_row_mask,
    input  wire logic [dklp_pkg::ROW_W-1:0]          i_subset_mask,
    output logic                                     o_done,
    output logic                                     o_is_plex,
    output logic                                     o_is_maximal,
    output logic      [dklp_pkg::CNT_W-1:0]          o_set_size,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [dklp_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [dklp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [dklp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_PICK  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [dklp_pkg::CNT_W-1:0]      r_out_slack;
    logic [dklp_pkg::CNT_W-1:0]      r_in_slack;
    logic [dklp_pkg::CNT_W-1:0]      r_vertex_count;
    logic [dklp_pkg::ROW_W-1:0]      r_set, n_set;
    logic [dklp_pkg::ROW_W-1:0]      r_tset, n_tset;
    logic [dklp_pkg::CNT_W-1:0]      r_size, n_size;
    logic [dklp_pkg::CNT_W-1:0]      r_bound, n_bound;
    logic [dklp_pkg::CNT_W-1:0]      r_nv, n_nv;
    logic [dklp_pkg::CNT_W-1:0]      r_v, n_v;
    logic [dklp_pkg::CNT_W-1:0]      r_cand, n_cand;
    logic                            r_cand_phase, n_cand_phase;
    logic [1:0]                      r_drain, n_drain;
    logic                            r_is_plex, n_is_plex;
    logic                            r_is_maximal, n_is_maximal;

    logic                            accept;
    logic                            cfg_wr;
    logic [1:0]                      cfg_idx;
    logic [dklp_pkg::CNT_W-1:0]      nv;
    logic [dklp_pkg::ROW_W-1:0]      used;
    logic [dklp_pkg::ROW_W-1:0]      set_in;
    logic [dklp_pkg::CNT_W-1:0]      size_in;
    logic                            row_ok;
    logic                            we_out;
    logic                            we_in;
    logic [dklp_pkg::ROW_W-1:0]      out_row;
    logic [dklp_pkg::ROW_W-1:0]      in_row;
    logic                            fail;
    dklp_pkg::t_deg_ctl              deg_ctl;

    assign busy = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_slack <= dklp_pkg::OUT_SLACK_RST;
            r_in_slack <= dklp_pkg::IN_SLACK_RST;
            r_vertex_count <= dklp_pkg::VERTEX_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                dklp_pkg::REG_OUT_SLACK: r_out_slack <= pwdata[dklp_pkg::CNT_W-1:0];
                dklp_pkg::REG_IN_SLACK: r_in_slack <= pwdata[dklp_pkg::CNT_W-1:0];
                dklp_pkg::REG_VERTEX_COUNT: r_vertex_count <= pwdata[dklp_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            dklp_pkg::REG_OUT_SLACK: prdata = dklp_pkg::APB_DATA_W'(r_out_slack);
            dklp_pkg::REG_IN_SLACK: prdata = dklp_pkg::APB_DATA_W'(r_in_slack);
            dklp_pkg::REG_VERTEX_COUNT: prdata = dklp_pkg::APB_DATA_W'(r_vertex_count);
            default: prdata = '0;
        endcase
    end

    assign nv = (r_vertex_count > dklp_pkg::CNT_W'(dklp_pkg::VERTICES)) ?
                dklp_pkg::CNT_W'(dklp_pkg::VERTICES) : r_vertex_count;

    always_comb begin
        for (int i = 0; i < dklp_pkg::ROW_W; i++) begin
            used[i] = (dklp_pkg::CNT_W'(i) < nv);
        end
    end

    assign set_in = i_subset_mask & used;
    assign size_in = dklp_pkg::popcount(set_in);

    assign row_ok = (dklp_pkg::CNT_W'(i_row_index) < dklp_pkg::CNT_W'(dklp_pkg::VERTICES));
    assign we_out = accept && (i_command == dklp_pkg::CMD_OUT_ROW) && row_ok;
    assign we_in = accept && (i_command == dklp_pkg::CMD_IN_ROW) && row_ok;

    dklp_adj_mem u_out_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we_out),
        .i_waddr (i_row_index[dklp_pkg::ADDR_W-1:0]),
        .i_wdata (i_row_mask),
        .i_raddr (r_v[dklp_pkg::ADDR_W-1:0]),
        .o_rdata (out_row)
    );

    dklp_adj_mem u_in_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we_in),
        .i_waddr (i_row_index[dklp_pkg::ADDR_W-1:0]),
        .i_wdata (i_row_mask),
        .i_raddr (r_v[dklp_pkg::ADDR_W-1:0]),
        .o_rdata (in_row)
    );

    dklp_degree_unit u_degree (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (deg_ctl),
        .i_out_row   (out_row),
        .i_in_row    (in_row),
        .i_tset      (r_tset),
        .i_bound     (r_bound),
        .i_out_slack (r_out_slack),
        .i_in_slack  (r_in_slack),
        .o_fail      (fail)
    );

    always_comb begin
        n_state = r_state;
        n_set = r_set;
        n_tset = r_tset;
        n_size = r_size;
        n_bound = r_bound;
        n_nv = r_nv;
        n_v = r_v;
        n_cand = r_cand;
        n_cand_phase = r_cand_phase;
        n_drain = r_drain;
        n_is_plex = r_is_plex;
        n_is_maximal = r_is_maximal;
        deg_ctl = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_command == dklp_pkg::CMD_CHECK)) begin
                    n_set = set_in;
                    n_tset = set_in;
                    n_size = size_in;
                    n_bound = size_in;
                    n_nv = nv;
                    n_v = '0;
                    n_cand = '0;
                    n_cand_phase = 1'b0;
                    if (nv == '0) begin
                        n_is_plex = 1'b1;
                        n_is_maximal = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        deg_ctl.clear = 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                deg_ctl.valid = 1'b1;
                deg_ctl.member = r_tset[r_v[dklp_pkg::SET_IDX_W-1:0]];
                n_v = r_v + dklp_pkg::CNT_W'(1);
                if (r_v == r_nv - dklp_pkg::CNT_W'(1)) begin
                    n_drain = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_drain == dklp_pkg::DRAIN_LAST) begin
                    if (!r_cand_phase) begin
                        if (fail) begin
                            n_is_plex = 1'b0;
                            n_is_maximal = 1'b0;
                            n_state = ST_DONE;
                        end else begin
                            n_is_plex = 1'b1;
                            n_cand_phase = 1'b1;
                            n_cand = '0;
                            n_state = ST_PICK;
                        end
                    end else begin
                        if (!fail) begin
                            n_is_maximal = 1'b0;
                            n_state = ST_DONE;
                        end else begin
                            n_cand = r_cand + dklp_pkg::CNT_W'(1);
                            n_state = ST_PICK;
                        end
                    end
                end else begin
                    n_drain = r_drain + 2'd1;
                end
            end
            ST_PICK: begin
                if (r_cand == r_nv) begin
                    n_is_maximal = 1'b1;
                    n_state = ST_DONE;
                end else if (r_set[r_cand[dklp_pkg::SET_IDX_W-1:0]]) begin
                    n_cand = r_cand + dklp_pkg::CNT_W'(1);
                end else begin
                    n_tset = r_set |
                             (dklp_pkg::ROW_W'(1) << r_cand[dklp_pkg::SET_IDX_W-1:0]);
                    n_bound = r_size + dklp_pkg::CNT_W'(1);
                    n_v = '0;
                    deg_ctl.clear = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_set <= n_set;
        r_tset <= n_tset;
        r_size <= n_size;
        r_bound <= n_bound;
        r_nv <= n_nv;
        r_v <= n_v;
        r_cand <= n_cand;
        r_cand_phase <= n_cand_phase;
        r_drain <= n_drain;
        r_is_plex <= n_is_plex;
        r_is_maximal <= n_is_maximal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_done = (r_state == ST_DONE);
    assign o_is_plex = r_is_plex;
    assign o_is_maximal = r_is_maximal;
    assign o_set_size = r_size;

endmodule
`default_nettype wire

### verif/directed_kl_plex_checker_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the directed (k,l)-plex checker: a directed table, then random phases.
module directed_kl_plex_checker_test;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int PHASES = 6;

    typedef struct packed {
        logic                       is_plex;
        logic                       is_maximal;
        logic [dklp_pkg::CNT_W-1:0] set_size;
    } t_check;

    typedef struct packed {
        logic        reg_write;
        logic [1:0]  code;
        logic [5:0]  row;
        logic [63:0] row_bits;
        logic [63:0] subset;
        logic        typed;
        t_check      want;
    } t_step;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic [1:0]                      i_command;
    logic [5:0]                      i_row_index;
    logic [dklp_pkg::ROW_W-1:0]      i_row_mask;
    logic [dklp_pkg::ROW_W-1:0]      i_subset_mask;
    logic                            o_done;
    logic                            o_is_plex;
    logic                            o_is_maximal;
    logic [dklp_pkg::CNT_W-1:0]      o_set_size;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [dklp_pkg::APB_ADDR_W-1:0] paddr;
    logic [dklp_pkg::APB_DATA_W-1:0] pwdata;
    logic [dklp_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    logic [63:0]                out_adj [dklp_pkg::VERTICES];
    logic [63:0]                in_adj [dklp_pkg::VERTICES];
    int                         slack_out;
    int                         slack_in;
    logic [dklp_pkg::CNT_W-1:0] vcount;

    logic [63:0] out_gen [dklp_pkg::VERTICES];
    logic [63:0] in_gen [dklp_pkg::VERTICES];
    t_check      expected_checks [$];
    t_check      head;
    t_step       plan [$];
    logic        typed_known;
    t_check      typed_exp;
    int          idle_pct;
    int          errors;
    int          quiet_cycles;

    int phase_out_k [PHASES] = '{1, 2, 0, 3, 1, 64};
    int phase_in_l [PHASES] = '{1, 1, 0, 3, 2, 0};
    int phase_vc [PHASES] = '{6, 8, 5, 64, 7, 10};
    int phase_idle [PHASES] = '{0, 66, 20, 66, 0, 20};

    directed_kl_plex_checker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_row_index   (i_row_index),
        .i_row_mask    (i_row_mask),
        .i_subset_mask (i_subset_mask),
        .o_done        (o_done),
        .o_is_plex     (o_is_plex),
        .o_is_maximal  (o_is_maximal),
        .o_set_size    (o_set_size),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic int in_use();
        return int'(vcount) > dklp_pkg::VERTICES ? dklp_pkg::VERTICES : int'(vcount);
    endfunction

    function automatic logic [63:0] used_mask(int nv);
        return nv >= 64 ? '1 : (64'd1 << nv) - 64'd1;
    endfunction

    function automatic logic [63:0] dense_row();
        return {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
    endfunction

    function automatic logic plex_holds(logic [63:0] members, int nv);
        int n;
        int v;
        n = $countones(members);
        for (v = 0; v < nv; v++) begin
            if (members[v] && ($countones(out_adj[v] & members) + slack_out < n ||
                               $countones(in_adj[v] & members) + slack_in < n)) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_check predict_check(logic [63:0] subset);
        t_check r;
        logic [63:0] members;
        int nv;
        int v;
        nv = in_use();
        members = subset & used_mask(nv);
        r.is_plex = plex_holds(members, nv);
        r.is_maximal = r.is_plex;
        if (r.is_plex) begin
            for (v = 0; v < nv; v++) begin
                if (!members[v] && plex_holds(members | (64'd1 << v), nv)) begin
                    r.is_maximal = 1'b0;
                    break;
                end
            end
        end
        r.set_size = dklp_pkg::CNT_W'($countones(members));
        return r;
    endfunction

    // Greedy growth from an empty set gives a maximal plex, since removing a member
    // never breaks the degree bounds.
    function automatic logic [63:0] grow_maximal(int nv);
        logic [63:0] members;
        int off;
        int i;
        int v;
        members = '0;
        off = $urandom_range(nv - 1);
        for (i = 0; i < nv; i++) begin
            v = (off + i) % nv;
            if (plex_holds(members | (64'd1 << v), nv)) begin
                members[v] = 1'b1;
            end
        end
        return members;
    endfunction

    function automatic void add_step(logic rw, logic [1:0] code, logic [5:0] row,
                                     logic [63:0] rbits, logic [63:0] sub, logic typed,
                                     logic pl, logic mx, logic [dklp_pkg::CNT_W-1:0] sz);
        t_step s;
        s.reg_write = rw;
        s.code = code;
        s.row = row;
        s.row_bits = rbits;
        s.subset = sub;
        s.typed = typed;
        s.want = '{is_plex: pl, is_maximal: mx, set_size: sz};
        plan.push_back(s);
    endfunction

    task automatic wait_slot();
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic present(logic [1:0] cmd, logic [5:0] row, logic [63:0] rbits,
                           logic [63:0] sub, logic typed, t_check want);
        start <= 1'b1;
        i_command <= cmd;
        i_row_index <= row;
        i_row_mask <= rbits;
        i_subset_mask <= sub;
        typed_known <= typed;
        typed_exp <= want;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_checks.size() != 0 || busy !== 1'b0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_register(logic [1:0] idx, logic [dklp_pkg::CNT_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= dklp_pkg::APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== dklp_pkg::APB_DATA_W'(value)) begin
            $error("prdata mismatch at register %0d: expected %0d, got %0d",
                   idx, value, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_noise(int nload);
        if ($urandom_range(9) == 0) begin
            wait_slot();
            if ($urandom_range(1) == 1) begin
                present(CMD_UNUSED, 6'($urandom_range(63)), {$urandom, $urandom},
                        {$urandom, $urandom}, 1'b0, '0);
            end else begin
                present($urandom_range(1) == 1 ? dklp_pkg::CMD_OUT_ROW : dklp_pkg::CMD_IN_ROW,
                        6'($urandom_range(63, nload)), {$urandom, $urandom},
                        {$urandom, $urandom}, 1'b0, '0);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (expected_checks.size() == 0) begin
                    $error("check result arrived with no check pending");
                    errors++;
                end else begin
                    head = expected_checks.pop_front();
                    if (o_is_plex !== head.is_plex) begin
                        $error("is_plex mismatch: expected %0b, got %0b",
                               head.is_plex, o_is_plex);
                        errors++;
                    end
                    if (o_is_maximal !== head.is_maximal) begin
                        $error("is_maximal mismatch: expected %0b, got %0b",
                               head.is_maximal, o_is_maximal);
                        errors++;
                    end
                    if (o_set_size !== head.set_size) begin
                        $error("set_size mismatch: expected %0d, got %0d",
                               head.set_size, o_set_size);
                        errors++;
                    end
                end
            end
            if (start && busy === 1'b0) begin
                case (i_command)
                    dklp_pkg::CMD_OUT_ROW: out_adj[i_row_index] = i_row_mask;
                    dklp_pkg::CMD_IN_ROW: in_adj[i_row_index] = i_row_mask;
                    dklp_pkg::CMD_CHECK: expected_checks.push_back(typed_known ? typed_exp :
                                                         predict_check(i_subset_mask));
                    default: ;
                endcase
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    dklp_pkg::REG_OUT_SLACK: slack_out = int'(pwdata[dklp_pkg::CNT_W-1:0]);
                    dklp_pkg::REG_IN_SLACK: slack_in = int'(pwdata[dklp_pkg::CNT_W-1:0]);
                    dklp_pkg::REG_VERTEX_COUNT: vcount = pwdata[dklp_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int p;
        int i;
        int j;
        int u;
        int v;
        int nv;
        int nload;
        logic [63:0] members;
        t_step s;

        start = 1'b0;
        i_command = dklp_pkg::CMD_OUT_ROW;
        i_row_index = '0;
        i_row_mask = '0;
        i_subset_mask = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        typed_known = 1'b0;
        typed_exp = '0;
        idle_pct = 0;
        errors = 0;
        quiet_cycles = 0;
        for (v = 0; v < dklp_pkg::VERTICES; v++) begin
            out_adj[v] = '0;
            in_adj[v] = '0;
        end
        slack_out = int'(dklp_pkg::OUT_SLACK_RST);
        slack_in = int'(dklp_pkg::IN_SLACK_RST);
        vcount = dklp_pkg::VERTEX_COUNT_RST;

        i_rst_n = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        add_step(0, dklp_pkg::CMD_CHECK, 6'd0, '0, '0, 1, 1, 0, 7'd0);
        add_step(0, dklp_pkg::CMD_CHECK, 6'd63, '1, '1, 1, 0, 0, 7'd64);
        add_step(0, dklp_pkg::CMD_CHECK, 6'd0, '0, 64'h8000_0000_0000_0000, 1, 1, 0, 7'd1);
        add_step(0, dklp_pkg::CMD_CHECK, 6'd0, '0, 64'h7, 1, 0, 0, 7'd3);
        add_step(0, dklp_pkg::CMD_CHECK, 6'd0, '0, 64'h8000_0000_0000_0001, 1, 1, 1, 7'd2);
        add_step(0, CMD_UNUSED, 6'd63, '1, '1, 0, 0, 0, 7'd0);
        add_step(0, dklp_pkg::CMD_OUT_ROW, 6'd0, '1, '0, 0, 0, 0, 7'd0);
        add_step(0, dklp_pkg::CMD_IN_ROW, 6'd0, '1, '0, 0, 0, 0, 7'd0);
        add_step(0, dklp_pkg::CMD_OUT_ROW, 6'd63, '0, '1, 0, 0, 0, 7'd0);
        add_step(0, dklp_pkg::CMD_IN_ROW, 6'd63, 64'hAAAA_AAAA_AAAA_AAAA, '0, 0, 0, 0, 7'd0);
        add_step(0, dklp_pkg::CMD_CHECK, 6'd0, '0, '1, 0, 0, 0, 7'd0);
        add_step(1, dklp_pkg::REG_VERTEX_COUNT, 6'd0, '0, 64'd0, 0, 0, 0, 7'd0);
        add_step(0, dklp_pkg::CMD_CHECK, 6'd0, '0, '1, 1, 1, 1, 7'd0);
        add_step(1, dklp_pkg::REG_VERTEX_COUNT, 6'd0, '0, 64'd100, 0, 0, 0, 7'd0);
        add_step(1, dklp_pkg::REG_OUT_SLACK, 6'd0, '0, 64'd64, 0, 0, 0, 7'd0);
        add_step(1, dklp_pkg::REG_IN_SLACK, 6'd0, '0, 64'd64, 0, 0, 0, 7'd0);
        add_step(0, dklp_pkg::CMD_CHECK, 6'd0, '0, '1, 1, 1, 1, 7'd64);
        add_step(1, dklp_pkg::REG_OUT_SLACK, 6'd0, '0, 64'd0, 0, 0, 0, 7'd0);
        add_step(1, dklp_pkg::REG_IN_SLACK, 6'd0, '0, 64'd0, 0, 0, 0, 7'd0);
        add_step(0, dklp_pkg::CMD_CHECK, 6'd0, '0, '0, 0, 0, 0, 7'd0);
        add_step(0, dklp_pkg::CMD_CHECK, 6'd0, '0, '1, 0, 0, 0, 7'd0);
        add_step(1, dklp_pkg::REG_VERTEX_COUNT, 6'd0, '0, 64'd1, 0, 0, 0, 7'd0);
        add_step(0, dklp_pkg::CMD_CHECK, 6'd0, '0, '1, 0, 0, 0, 7'd0);
        add_step(0, dklp_pkg::CMD_CHECK, 6'd0, '0, '0, 0, 0, 0, 7'd0);

        for (j = 0; j < plan.size(); j++) begin
            s = plan[j];
            if (s.reg_write) begin
                settle();
                set_register(s.code, s.subset[dklp_pkg::CNT_W-1:0]);
            end else begin
                wait_slot();
                present(s.code, s.row, s.row_bits, s.subset, s.typed, s.want);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            settle();
            set_register(dklp_pkg::REG_OUT_SLACK, dklp_pkg::CNT_W'(phase_out_k[p]));
            set_register(dklp_pkg::REG_IN_SLACK, dklp_pkg::CNT_W'(phase_in_l[p]));
            set_register(dklp_pkg::REG_VERTEX_COUNT, dklp_pkg::CNT_W'(phase_vc[p]));
            idle_pct = phase_idle[p];
            nv = phase_vc[p] > dklp_pkg::VERTICES ? dklp_pkg::VERTICES : phase_vc[p];
            nload = nv < 8 ? nv : 8;
            for (v = 0; v < dklp_pkg::VERTICES; v++) begin
                out_gen[v] = dense_row();
            end
            for (v = 0; v < dklp_pkg::VERTICES; v++) begin
                if (p % 2 == 0) begin
                    for (u = 0; u < dklp_pkg::VERTICES; u++) begin
                        in_gen[v][u] = out_gen[u][v];
                    end
                end else begin
                    in_gen[v] = dense_row();
                end
            end
            for (v = 0; v < nload; v++) begin
                add_noise(nload);
                wait_slot();
                present(dklp_pkg::CMD_OUT_ROW, 6'(v), out_gen[v], {$urandom, $urandom},
                        1'b0, '0);
                wait_slot();
                present(dklp_pkg::CMD_IN_ROW, 6'(v), in_gen[v], {$urandom, $urandom},
                        1'b0, '0);
            end
            for (i = 0; i < (nv == dklp_pkg::VERTICES ? 4 : 6); i++) begin
                add_noise(nload);
                wait_slot();
                case ($urandom_range(3))
                    0: members = grow_maximal(nv);
                    1: begin
                        members = grow_maximal(nv);
                        members[$urandom_range(nv - 1)] = 1'b0;
                    end
                    2: members = dense_row() & used_mask(nv);
                    default: members = {$urandom, $urandom};
                endcase
                members = members | ({$urandom, $urandom} & ~used_mask(nv));
                present(dklp_pkg::CMD_CHECK, 6'($urandom_range(63)), {$urandom, $urandom},
                        members, 1'b0, '0);
            end
        end

        settle();
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
src/dklp_pkg.sv
src/dklp_adj_mem.sv
src/dklp_degree_unit.sv
src/directed_kl_plex_checker.sv
verif/directed_kl_plex_checker_test.sv
